FILE: hdl/matrix_multiply_unit_macros.svh
// Assertion macros shared by the matrix multiply unit.
`ifndef MATRIX_MULTIPLY_UNIT_MACROS_SVH
`define MATRIX_MULTIPLY_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define MMU_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define MMU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define MMU_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define MMU_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: hdl/mmu_pkg.sv
// Types and constants of the matrix multiply unit.
`default_nettype none
package mmu_pkg;
   localparam int MAX_DIM = 8;
   localparam int IDX_W   = $clog2(MAX_DIM);
   localparam int DIM_W   = 4;
   localparam int VAL_W   = 32;
   localparam int ACC_W   = 2 * VAL_W + IDX_W;

   localparam logic [1:0] OP_WRITE_A = 2'd0;
   localparam logic [1:0] OP_WRITE_B = 2'd1;
   localparam logic [1:0] OP_COMPUTE = 2'd2;

   localparam logic [1:0] CSR_A_ROWS = 2'd0;
   localparam logic [1:0] CSR_A_COLS = 2'd1;
   localparam logic [1:0] CSR_B_ROWS = 2'd2;
   localparam logic [1:0] CSR_B_COLS = 2'd3;

   typedef struct packed {
      logic [1:0]              op;
      logic [2:0]              row_index;
      logic [2:0]              col_index;
      logic signed [VAL_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [2:0]              out_row;
      logic [2:0]              out_col;
      logic signed [VAL_W-1:0] product;
      logic                    saturated;
      logic                    last;
   } rsp_type;

   typedef struct packed {
      logic clear;
      logic mul_en;
      logic acc_en;
      logic shift;
   } cell_ctrl_type;
endpackage
`default_nettype wire

FILE: hdl/mmu_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module mmu_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end
endmodule
`default_nettype wire

FILE: hdl/mmu_cell.sv
// One multiply-accumulate cell of the output row chain.
`default_nettype none
module mmu_cell (
   input  wire logic                                  clock,
   input  wire mmu_pkg::cell_ctrl_type                ctrl,
   input  wire logic signed [mmu_pkg::VAL_W-1:0]      a_value,
   input  wire logic signed [mmu_pkg::VAL_W-1:0]      b_value,
   input  wire logic signed [mmu_pkg::ACC_W-1:0]      shift_in,
   output logic signed      [mmu_pkg::ACC_W-1:0]      acc_out
);
   import mmu_pkg::*;

   logic signed [2*VAL_W-1:0] prod_ff;
   logic signed [ACC_W-1:0]   acc_ff;

   always_ff @(posedge clock) begin
      if (ctrl.mul_en) begin
         prod_ff <= a_value * b_value;
      end
      if (ctrl.clear) begin
         acc_ff <= '0;
      end else if (ctrl.acc_en) begin
         acc_ff <= acc_ff + ACC_W'(prod_ff);
      end else if (ctrl.shift) begin
         acc_ff <= shift_in;
      end
   end

   assign acc_out = acc_ff;
endmodule
`default_nettype wire

FILE: hdl/matrix_multiply_unit.sv
// Top level of the matrix multiply unit: element stores, cell chain and control.
`default_nettype none
// Matrix multiply unit. Requests with op 0 and op 1 write one Q16.16 element of
// A or B. A compute request produces C = A x B row by row: for each row of C,
// the n = a_cols elements of that A row are read one per cycle and broadcast
// to a chain of eight multiply-accumulate cells, one per column of C, each fed
// by its own B column store. Once the pipeline has drained, the row's sums
// shift along the chain, one result per cycle out of the head cell while the
// response is not stalled, shifted back to Q16.16 and saturated. When the
// sizes do not match or a_cols is zero, zero results are shifted out
// directly; when a_rows or b_cols is zero, no results are produced. New
// requests are stalled until the last result has been loaded into the output
// register. Configuration writes are always ready.
module matrix_multiply_unit (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire mmu_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output mmu_pkg::rsp_type      rsp_data,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [1:0]       csr_index,
   input  wire logic [3:0]       csr_data
);
   import mmu_pkg::*;
`include "matrix_multiply_unit_macros.svh"

   typedef enum logic [1:0] {S_IDLE, S_RUN, S_WAIT, S_DRAIN} state_type;

   state_type      state_ff;
   logic [DIM_W-1:0] a_rows_ff, a_cols_ff, b_rows_ff, b_cols_ff;
   logic [IDX_W-1:0] i_ff, k_ff, j_ff;
   logic           v1_ff, v2_ff, clear_ff, valid_ff;
   logic           out_valid_ff;
   rsp_type        out_ff;

   // Register values above the store size are used as the store size.
   function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] d);
      return (d > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : d;
   endfunction

   logic [DIM_W-1:0] ar, ac, br, bc;
   logic             sizes_ok;
   assign ar = eff_dim(a_rows_ff);
   assign ac = eff_dim(a_cols_ff);
   assign br = eff_dim(b_rows_ff);
   assign bc = eff_dim(b_cols_ff);
   assign sizes_ok = (ac == br) && (ar != '0) && (ac != '0) && (bc != '0);

   logic req_acc, issue, load_out, row_done, last_row, start, next_row;
   assign req_stall = (state_ff != S_IDLE);
   assign req_acc   = req_valid && !req_stall;
   assign issue     = (state_ff == S_RUN);
   assign load_out  = (state_ff == S_DRAIN) && (!out_valid_ff || !rsp_stall);
   assign row_done  = ({1'b0, j_ff} == bc - 1'b1);
   assign last_row  = ({1'b0, i_ff} == ar - 1'b1);
   // A compute request with at least one result starts a product.
   assign start     = req_acc && req_data.op == OP_COMPUTE && ar != '0 && bc != '0;
   // The last result of a row that is not the final row opens the next row.
   assign next_row  = load_out && row_done && !last_row;

   // Element stores: A as one store, B split into one store per column.
   logic signed [VAL_W-1:0] a_rd;
   logic        [VAL_W-1:0] a_rd_raw;
   logic        [VAL_W-1:0] b_rd [MAX_DIM];

   mmu_ram #(.WIDTH(VAL_W), .DEPTH(MAX_DIM * MAX_DIM)) u_a_ram (
      .clock   (clock),
      .wr_en   (req_acc && req_data.op == OP_WRITE_A),
      .wr_addr ({req_data.row_index, req_data.col_index}),
      .wr_data (req_data.value),
      .rd_en   (issue),
      .rd_addr ({i_ff, k_ff}),
      .rd_data (a_rd_raw)
   );
   assign a_rd = a_rd_raw;

   logic signed [ACC_W-1:0] acc [MAX_DIM+1];
   cell_ctrl_type           cell_ctrl;
   assign cell_ctrl.clear  = clear_ff;
   assign cell_ctrl.mul_en = v1_ff;
   assign cell_ctrl.acc_en = v2_ff;
   assign cell_ctrl.shift  = load_out;
   assign acc[MAX_DIM] = '0;

   for (genvar g = 0; g < MAX_DIM; g++) begin : g_col
      mmu_ram #(.WIDTH(VAL_W), .DEPTH(MAX_DIM)) u_b_ram (
         .clock   (clock),
         .wr_en   (req_acc && req_data.op == OP_WRITE_B
                   && req_data.col_index == IDX_W'(g)),
         .wr_addr (req_data.row_index),
         .wr_data (req_data.value),
         .rd_en   (issue),
         .rd_addr (k_ff),
         .rd_data (b_rd[g])
      );
      mmu_cell u_cell (
         .clock    (clock),
         .ctrl     (cell_ctrl),
         .a_value  (a_rd),
         .b_value  (signed'(b_rd[g])),
         .shift_in (acc[g+1]),
         .acc_out  (acc[g])
      );
   end

   // The head sum is Q32.32; keep bits 47:16 when bits 66:47 are all equal.
   logic                 head_sat;
   logic [VAL_W-1:0]     head_val;
   assign head_sat = !((&acc[0][ACC_W-1:47]) || !(|acc[0][ACC_W-1:47]));
   assign head_val = head_sat ? (acc[0][ACC_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF)
                              : acc[0][47:16];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         a_rows_ff    <= '0;
         a_cols_ff    <= '0;
         b_rows_ff    <= '0;
         b_cols_ff    <= '0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         clear_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
         valid_ff     <= 1'b0;
         i_ff         <= '0;
         k_ff         <= '0;
         j_ff         <= '0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               CSR_A_ROWS: a_rows_ff <= csr_data;
               CSR_A_COLS: a_cols_ff <= csr_data;
               CSR_B_ROWS: b_rows_ff <= csr_data;
               CSR_B_COLS: b_cols_ff <= csr_data;
               default:    a_rows_ff <= a_rows_ff;
            endcase
         end
         v1_ff        <= issue;
         v2_ff        <= v1_ff;
         clear_ff     <= start || next_row;
         out_valid_ff <= load_out || (out_valid_ff && rsp_stall);
         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  i_ff     <= '0;
                  k_ff     <= '0;
                  j_ff     <= '0;
                  valid_ff <= sizes_ok;
                  state_ff <= sizes_ok ? S_RUN : S_DRAIN;
               end
            end
            S_RUN: begin
               if ({1'b0, k_ff} == ac - 1'b1) begin
                  k_ff     <= '0;
                  state_ff <= S_WAIT;
               end else begin
                  k_ff <= k_ff + 1'b1;
               end
            end
            S_WAIT: begin
               if (!v1_ff && !v2_ff) begin
                  state_ff <= S_DRAIN;
               end
            end
            S_DRAIN: begin
               if (load_out) begin
                  out_ff.out_row    <= i_ff;
                  out_ff.out_col    <= j_ff;
                  // Mismatched sizes give zeros whatever the chain holds.
                  out_ff.product    <= valid_ff ? head_val : '0;
                  out_ff.saturated  <= valid_ff && head_sat;
                  out_ff.last       <= row_done && last_row;
                  if (row_done) begin
                     j_ff <= '0;
                     if (last_row) begin
                        state_ff <= S_IDLE;
                     end else begin
                        i_ff     <= i_ff + 1'b1;
                        state_ff <= valid_ff ? S_RUN : S_DRAIN;
                     end
                  end else begin
                     j_ff <= j_ff + 1'b1;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign csr_ready = 1'b1;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   // Products only move through the pipeline while a row is being summed.
   `MMU_ASSERT_IMPLY(a_pipe_busy, clock, reset, v2_ff, state_ff == S_RUN || state_ff == S_WAIT)
   // The chain never shifts while sums are still being accumulated.
   `MMU_ASSERT_IMPLY(a_drain_quiet, clock, reset, state_ff == S_DRAIN, !v1_ff && !v2_ff)
   // Loading the final result of a product returns the unit to idle.
   `MMU_ASSERT_NEXT(a_last_idle, clock, reset, load_out && row_done && last_row,
                    state_ff == S_IDLE && rsp_valid && rsp_data.last)
endmodule
`default_nettype wire
